@@ hdl/lsrd_pkg.sv @@
// lsrd_pkg: shared types and constants of the scan reply deframer
// no dependencies; imported by every module under hdl

package lsrd_pkg;

  // byte codes and framing sizes
  localparam logic [7:0]  LINE_FEED        = 8'h0A;
  localparam logic [5:0]  CHAR_BIAS        = 6'h30;
  localparam logic [6:0]  BLOCK_LAST       = 7'd65;
  localparam logic [6:0]  DATA_PER_BLOCK   = 7'd64;
  localparam logic [13:0] SIZE_BASE        = 14'd103;
  localparam logic [12:0] COUNT_MAX        = 13'd8191;
  localparam logic [1:0]  HEADER_LF_LAST   = 2'd2;
  localparam logic [1:0]  CHARS_PER_VALUE  = 2'd2;
  localparam logic [11:0] BEAM_COUNT_RESET = 12'd1081;

  // kind of result item
  typedef enum logic {
    KIND_RANGE = 1'b0,
    KIND_END   = 1'b1
  } result_kind_t;

  // one result item
  typedef struct packed {
    result_kind_t kind;
    logic [10:0]  beam_slot;
    logic [15:0]  range_value;
    logic         size_ok;
  } result_t;

endpackage

@@ hdl/lidar_scan_reply_deframer.sv @@
// lidar_scan_reply_deframer: one byte per cycle; from byte transfer to result a
// byte passes the input register, then is decoded into the result register.
// Throughput is one byte every cycle; only a stalled output holds the input.
// Synchronous active-low reset returns to the header phase with an empty
// pipeline and beam_count 1081.
// depends on lsrd_pkg, lsrd_in_stage, lsrd_decode, lsrd_out_reg

module lidar_scan_reply_deframer
  import lsrd_pkg::*;
#(
  parameter int MAX_BEAMS = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [10:0] out_beam_slot,
  output logic [15:0] out_range_value,
  output logic        out_size_ok
);

  logic [11:0] beam_count_r;
  logic        can_take;
  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        res_valid;
  result_t     res;

  // beam count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_count_r <= BEAM_COUNT_RESET;
    end else if (cfg_wr_en) begin
      beam_count_r <= cfg_wr_data;
    end
  end

  lsrd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (can_take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  lsrd_decode #(
    .MAX_BEAMS (MAX_BEAMS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (byte_valid && can_take),
    .rx_byte    (byte_data),
    .beam_count (beam_count_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  lsrd_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .can_take        (can_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_beam_slot   (out_beam_slot),
    .out_range_value (out_range_value),
    .out_size_ok     (out_size_ok)
  );

endmodule

@@ hdl/lsrd_in_stage.sv @@
// lsrd_in_stage: input register for received bytes
// depends on lsrd_pkg

module lsrd_in_stage
  import lsrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       load;

  // hold the byte only while the decoder cannot take it
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // byte payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

@@ hdl/lsrd_decode.sv @@
// lsrd_decode: framing state and per-byte range decode
// depends on lsrd_pkg

module lsrd_decode
  import lsrd_pkg::*;
#(
  parameter int MAX_BEAMS = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [11:0] beam_count,
  output logic        res_valid,
  output result_t     res
);

  localparam logic [12:0] MaxBeamsW = 13'(MAX_BEAMS);

  logic        in_data_r,   in_data_nxt;
  logic [1:0]  hdr_lf_r,    hdr_lf_nxt;
  logic        last_lf_r,   last_lf_nxt;
  logic [6:0]  pos_r,       pos_nxt;
  logic [1:0]  held_r,      held_nxt;
  logic [11:0] acc_r,       acc_nxt;
  logic [11:0] remain_r,    remain_nxt;
  logic [12:0] seen_r,      seen_nxt;

  logic        is_lf;
  logic [11:0] eff_beams;
  logic [13:0] expected;
  logic [12:0] seen_inc;
  logic [5:0]  chr;
  logic [11:0] remain_dec;

  // effective beam count and expected reply size
  assign is_lf      = (rx_byte == LINE_FEED);
  assign eff_beams  = ({1'b0, beam_count} > MaxBeamsW) ? MaxBeamsW[11:0] : beam_count;
  assign expected   = SIZE_BASE + {1'b0, eff_beams, 1'b0} + {2'b00, eff_beams};
  assign seen_inc   = (seen_r < COUNT_MAX) ? seen_r + 13'd1 : seen_r;
  assign chr        = rx_byte[5:0] - CHAR_BIAS;
  assign remain_dec = remain_r - 12'd1;

  // next state and result for one byte
  always_comb begin
    in_data_nxt = in_data_r;
    hdr_lf_nxt  = hdr_lf_r;
    last_lf_nxt = last_lf_r;
    pos_nxt     = pos_r;
    held_nxt    = held_r;
    acc_nxt     = acc_r;
    remain_nxt  = remain_r;
    seen_nxt    = seen_r;
    res_valid   = 1'b0;
    res         = '{kind: KIND_RANGE, beam_slot: '0, range_value: '0, size_ok: 1'b0};

    if (step) begin
      if (is_lf && last_lf_r) begin
        // doubled line feed ends the reply
        res_valid   = 1'b1;
        res.kind    = KIND_END;
        res.size_ok = in_data_r && (seen_inc < COUNT_MAX) && ({1'b0, seen_inc} == expected);
        in_data_nxt = 1'b0;
        hdr_lf_nxt  = '0;
        last_lf_nxt = 1'b0;
        pos_nxt     = '0;
        held_nxt    = '0;
        acc_nxt     = '0;
        remain_nxt  = '0;
        seen_nxt    = '0;
      end else if (!in_data_r) begin
        // header: count line feeds
        last_lf_nxt = is_lf;
        if (is_lf) begin
          if (hdr_lf_r >= HEADER_LF_LAST) begin
            in_data_nxt = 1'b1;
            hdr_lf_nxt  = '0;
            pos_nxt     = '0;
            held_nxt    = '0;
            acc_nxt     = '0;
            remain_nxt  = eff_beams;
            seen_nxt    = '0;
          end else begin
            hdr_lf_nxt = hdr_lf_r + 2'd1;
          end
        end
      end else begin
        // data section: block position and character decode
        last_lf_nxt = is_lf;
        seen_nxt    = seen_inc;
        pos_nxt     = (pos_r >= BLOCK_LAST) ? 7'd0 : pos_r + 7'd1;
        if (pos_r < DATA_PER_BLOCK && remain_r != '0) begin
          if (held_r >= CHARS_PER_VALUE) begin
            res_valid       = 1'b1;
            res.kind        = KIND_RANGE;
            res.beam_slot   = remain_dec[10:0];
            res.range_value = {acc_r[9:0], chr};
            remain_nxt      = remain_dec;
            held_nxt        = '0;
            acc_nxt         = '0;
          end else begin
            acc_nxt  = {acc_r[5:0], chr};
            held_nxt = held_r + 2'd1;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_data_r <= 1'b0;
      hdr_lf_r  <= '0;
      last_lf_r <= 1'b0;
      pos_r     <= '0;
      held_r    <= '0;
      acc_r     <= '0;
      remain_r  <= '0;
      seen_r    <= '0;
    end else begin
      in_data_r <= in_data_nxt;
      hdr_lf_r  <= hdr_lf_nxt;
      last_lf_r <= last_lf_nxt;
      pos_r     <= pos_nxt;
      held_r    <= held_nxt;
      acc_r     <= acc_nxt;
      remain_r  <= remain_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

@@ hdl/lsrd_out_reg.sv @@
// lsrd_out_reg: result register toward the output channel
// depends on lsrd_pkg

module lsrd_out_reg
  import lsrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  result_t     res,
  output logic        can_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [10:0] out_beam_slot,
  output logic [15:0] out_range_value,
  output logic        out_size_ok
);

  logic    valid_r;
  result_t res_r;

  // free, or emptied by a transfer in this cycle
  assign can_take = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = res_r.kind;
  assign out_beam_slot   = res_r.beam_slot;
  assign out_range_value = res_r.range_value;
  assign out_size_ok     = res_r.size_ok;

endmodule

@@ tb/lsrd_result_check.sv @@
// lsrd_result_check: watches the byte, result and config ports of the deframer,
// predicts each result from the accepted bytes and compares in order
// depends on lsrd_pkg

module lsrd_result_check
  import lsrd_pkg::*;
#(
  parameter int MAX_BEAMS = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [10:0] out_beam_slot,
  input  logic [15:0] out_range_value,
  input  logic        out_size_ok,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // keep the log short once things go wrong
  localparam int REPORT_LIMIT = 40;

  // predictor copy of the register and the framing state
  logic [11:0] beam_count;
  logic        in_data;
  logic        prev_lf;
  logic [1:0]  header_lines;
  logic [1:0]  chars_held;
  logic [6:0]  block_pos;
  logic [11:0] char_acc;
  logic [11:0] beams_left;
  logic [12:0] byte_count;

  result_t     pending_q[$];
  int          reported;

  initial begin
    fail_count = 0;
    pending_count = 0;
    reported = 0;
  end

  function automatic logic [12:0] effective_beams();
    return (beam_count > MAX_BEAMS) ? 13'(MAX_BEAMS) : {1'b0, beam_count};
  endfunction

  // back to the header phase
  task automatic clear_reply();
    in_data = 1'b0;
    prev_lf = 1'b0;
    header_lines = '0;
    chars_held = '0;
    block_pos = '0;
    char_acc = '0;
    beams_left = '0;
    byte_count = '0;
  endtask

  task automatic push_end(input logic ok);
    result_t r;
    r.kind = KIND_END;
    r.beam_slot = '0;
    r.range_value = '0;
    r.size_ok = ok;
    pending_q.push_back(r);
  endtask

  // advance the predictor by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    logic        is_lf;
    logic        ok;
    logic [6:0]  pos;
    logic [5:0]  c;
    logic [13:0] want_size;
    result_t     r;
    is_lf = (b == LINE_FEED);

    // header phase: count line feeds, a doubled one ends the reply
    if (!in_data) begin
      if (is_lf && prev_lf) begin
        clear_reply();
        push_end(1'b0);
        return;
      end
      prev_lf = is_lf;
      if (is_lf) begin
        if (header_lines >= HEADER_LF_LAST) begin
          in_data = 1'b1;
          header_lines = '0;
          block_pos = '0;
          chars_held = '0;
          char_acc = '0;
          beams_left = 12'(effective_beams());
          byte_count = '0;
        end else begin
          header_lines = header_lines + 1'b1;
        end
      end
      return;
    end

    // data phase: saturating byte count, doubled line feed closes the reply
    if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
    if (is_lf && prev_lf) begin
      want_size = SIZE_BASE + 14'(3 * effective_beams());
      ok = (byte_count != COUNT_MAX) && ({1'b0, byte_count} == want_size);
      clear_reply();
      push_end(ok);
      return;
    end
    prev_lf = is_lf;

    // block position walks 0..65, only the first 64 carry characters
    pos = block_pos;
    block_pos = (pos == BLOCK_LAST) ? '0 : pos + 1'b1;
    if (pos < DATA_PER_BLOCK && beams_left != '0) begin
      c = b[5:0] - CHAR_BIAS;
      if (chars_held == CHARS_PER_VALUE) begin
        beams_left = beams_left - 1'b1;
        r.kind = KIND_RANGE;
        r.beam_slot = beams_left[10:0];
        r.range_value = {char_acc[9:0], c};
        r.size_ok = 1'b0;
        pending_q.push_back(r);
        chars_held = '0;
        char_acc = '0;
      end else begin
        char_acc = {char_acc[5:0], c};
        chars_held = chars_held + 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (reported < REPORT_LIMIT)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      reported++;
    end
  endtask

  // results are compared before the same edge's byte is predicted
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      beam_count = BEAM_COUNT_RESET;
      clear_reply();
      pending_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          fail_count++;
          if (reported < REPORT_LIMIT)
            $error("result transfer with nothing expected: kind %0d slot %0d value %0d",
                   out_result_kind, out_beam_slot, out_range_value);
          reported++;
        end else begin
          want = pending_q.pop_front();
          check_field("result_kind", int'(want.kind), int'(out_result_kind));
          check_field("beam_slot", int'(want.beam_slot), int'(out_beam_slot));
          check_field("range_value", int'(want.range_value), int'(out_range_value));
          check_field("size_ok", int'(want.size_ok), int'(out_size_ok));
        end
      end
      if (in_valid && !in_stall) decode_byte(in_rx_byte);
      if (cfg_wr_en) beam_count = cfg_wr_data;
    end
    pending_count = pending_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: byte stimulus, result-side stall and beam_count writes for the deframer
// depends on lsrd_pkg, lidar_scan_reply_deframer and lsrd_result_check

module tb_top
  import lsrd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BEAMS    = 2048;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 40;

  // doubled lf in the header, a short data section with extreme characters,
  // an lf at a data position and an early end
  localparam logic [7:0] OPENING_BYTES [22] = '{
    8'h00, 8'hFF, LINE_FEED, LINE_FEED,
    8'h4D, LINE_FEED, 8'h80, LINE_FEED, 8'h7F, LINE_FEED,
    8'h30, 8'h30, 8'h30,
    8'h6F, 8'h6F, 8'h6F,
    8'h00, 8'hFF, LINE_FEED,
    8'h2F, LINE_FEED, LINE_FEED
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_result_kind;
  logic [10:0] out_beam_slot;
  logic [15:0] out_range_value;
  logic        out_size_ok;

  int fail_count;
  int pending_count;
  int send_idle_pct;
  int stall_pct;
  int bytes_sent;
  int beam_setting;
  int quiet_cycles;

  lidar_scan_reply_deframer #(
    .MAX_BEAMS(MAX_BEAMS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_beam_slot  (out_beam_slot),
    .out_range_value(out_range_value),
    .out_size_ok    (out_size_ok)
  );

  lsrd_result_check #(
    .MAX_BEAMS(MAX_BEAMS)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_beam_slot  (out_beam_slot),
    .out_range_value(out_range_value),
    .out_size_ok    (out_size_ok),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result-side stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transfer
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL lidar_scan_reply_deframer");
    $finish;
  end

  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == LINE_FEED) b = 8'h20;
    return b;
  endfunction

  // mostly scanner characters, some raw bytes and the odd lf
  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(99);
    if (r < 4) return LINE_FEED;
    if (r < 70) return 8'h30 + 8'($urandom_range(63));
    return 8'($urandom_range(255));
  endfunction

  function automatic int good_size();
    int eff;
    eff = (beam_setting > MAX_BEAMS) ? MAX_BEAMS : beam_setting;
    return int'(SIZE_BASE) + 3 * eff;
  endfunction

  // one byte transfer, with a random gap before it; returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    repeat ($urandom_range(1, 6)) send_byte(pick_text());
    send_byte(LINE_FEED);
  endtask

  // header lines, then a data section of the given length in bytes counted
  // up to and including the closing lf
  task automatic send_reply(input int total);
    logic [7:0] b;
    logic       prev_lf;
    int         len;
    len = (total < 3) ? 3 : total;
    repeat (3) send_line();
    prev_lf = 1'b1;
    for (int i = 0; i < len - 1; i++) begin
      if (i == len - 2) b = LINE_FEED;
      else if (i == len - 3) b = pick_text();
      else if (i % 66 == 65) b = LINE_FEED;
      else b = pick_data();
      if (b == LINE_FEED && prev_lf) b = pick_text();
      send_byte(b);
      prev_lf = (b == LINE_FEED);
    end
    send_byte(LINE_FEED);
  endtask

  // register write once the block has drained
  task automatic write_beams(input int n);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 12'(n);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    beam_setting = n;
  endtask

  // mostly well-formed replies, some with wrong length, broken headers
  // and noise; each noise burst is closed by a doubled lf to resync
  task automatic run_traffic(input int budget);
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_reply(good_size());
      end else if (r < 72) begin
        send_reply(good_size() + int'($urandom_range(40)) - 20);
      end else if (r < 80) begin
        send_reply($urandom_range(3, 60));
      end else if (r < 90) begin
        send_line();
        send_byte(LINE_FEED);
      end else begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
        send_byte(pick_text());
        send_byte(LINE_FEED);
        send_byte(LINE_FEED);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    beam_setting = int'(BEAM_COUNT_RESET);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed bytes at the reset beam count
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

    // sender idles less than the receiver stalls
    send_idle_pct = 29;
    stall_pct = 46;
    write_beams(1);
    run_traffic(PHASE_BYTES);
    write_beams(0);
    send_reply(good_size());

    // receiver stalls less than the sender idles, then a setting above the clamp
    send_idle_pct = 46;
    stall_pct = 29;
    write_beams($urandom_range(2, 8));
    run_traffic(PHASE_BYTES);
    write_beams(4095);
    send_reply($urandom_range(20, 40));

    // back to back
    send_idle_pct = 0;
    stall_pct = 0;
    write_beams($urandom_range(1, 8));
    run_traffic(PHASE_BYTES);

    // drain
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_count == 0)
      $display("PASS lidar_scan_reply_deframer");
    else
      $display("FAIL lidar_scan_reply_deframer");
    $finish;
  end

endmodule
